// File: design/frwlt_pkg.sv
`default_nettype none
package frwlt_pkg;

  // table geometry
  localparam int KEY_COUNT   = 1024;
  localparam int QUEUE_DEPTH = 128;
  localparam int KEY_W       = $clog2(KEY_COUNT);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int ID_ADDR_W   = KEY_W + QPTR_W;
  localparam int ID_DEPTH    = KEY_COUNT * QUEUE_DEPTH;

  // field widths
  localparam int REQ_W    = 3;
  localparam int TXID_W   = 20;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 8;
  localparam int RCNT_W   = 8;
  localparam int LIMIT_W  = 8;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;
  localparam logic [RCNT_W-1:0]  RCNT_MAX    = 8'hFF;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQ     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SHARED  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EXCL    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UPGRADE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REL_SH  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REL_EX  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_HEAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REL_ERR  = 3'd4;

  // per-key lock and queue record
  typedef struct packed {
    logic [RCNT_W-1:0] rcnt;
    logic              writer;
    logic [QPTR_W-1:0] head;
    logic [QPTR_W-1:0] tail;
    logic [FILL_W-1:0] fill;
  } meta_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic meta_rd;
    logic head_rd;
    logic exec;
    logic nhead_rd;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: design/fifo_ordered_rw_lock_table_top.sv
// FIFO-ordered reader/writer lock table.
// Input stream in_*: one lock request per item, in_tdata holds req_type,
// lock_key and tx_id. Output stream out_*: one result per request,
// out_tdata holds status, head_tx and queue_occupancy.
// cfg_*: writes queue_limit; always ready, write only while no request
// is in flight.
// Each request walks a fixed sequence: record read, head id read,
// decide and write back, new head id read, result load. A new request
// is taken only after the previous one has loaded its result.
// After reset the block clears its 1024 key records, one per cycle, and
// in_tready stays low until the clearing pass is done.
// A result waits in the output register while out_tready is low; one more
// request can be taken and worked on meanwhile, and it holds in its last
// step until the output register is free.
`default_nettype none
module fifo_ordered_rw_lock_table_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [2:0] req_type, [12:3] lock_key, [32:13] tx_id, rest zero
  input  wire logic [frwlt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] status, [22:3] head_tx, [30:23] queue_occupancy, rest zero
  output logic      [frwlt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [frwlt_pkg::LIMIT_W-1:0]       cfg_data
);
  import frwlt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  frwlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  frwlt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// File: design/frwlt_ctrl.sv
`default_nettype none
module frwlt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire frwlt_pkg::dp_stat_t stat,
  output frwlt_pkg::ctl_cmd_t     cmd
);
  import frwlt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_META,
    S_HEAD,
    S_EXEC,
    S_NHEAD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign load       = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.clr_wr   = (state_r == S_CLEAR);
    cmd.accept   = in_tready && in_tvalid;
    cmd.meta_rd  = (state_r == S_META);
    cmd.head_rd  = (state_r == S_HEAD);
    cmd.exec     = (state_r == S_EXEC);
    cmd.nhead_rd = (state_r == S_NHEAD);
    cmd.out_load = load;
  end

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_META;
      S_META:  state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_NHEAD;
      S_NHEAD: state_nxt = S_DONE;
      S_DONE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/frwlt_dp.sv
`default_nettype none
module frwlt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire frwlt_pkg::ctl_cmd_t                 cmd,
  output frwlt_pkg::dp_stat_t                      stat,
  input  wire logic [frwlt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic      [frwlt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                                cfg_valid,
  input  wire logic [frwlt_pkg::LIMIT_W-1:0]       cfg_data
);
  import frwlt_pkg::*;

  // storage
  meta_t             meta_mem [KEY_COUNT];
  logic [TXID_W-1:0] id_mem   [ID_DEPTH];

  logic [KEY_W-1:0]    clr_addr_r;
  logic [LIMIT_W-1:0]  queue_limit_r;
  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    key_r;
  logic [TXID_W-1:0]   id_r;
  meta_t               meta_q_r;
  logic [TXID_W-1:0]   id_q_r;
  logic [STATUS_W-1:0] status_r;
  logic [QPTR_W-1:0]   nhead_r;
  logic [FILL_W-1:0]   nfill_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TXID_W-1:0]   out_head_r;
  logic [FILL_W-1:0]   out_fill_r;

  logic [LIMIT_W-1:0]   limit_eff;
  logic                 at_head;
  logic                 enq_we;
  logic [STATUS_W-1:0]  status_nxt;
  meta_t                meta_nxt;
  logic                 meta_we;
  logic [KEY_W-1:0]     meta_waddr;
  meta_t                meta_wdata;
  logic [ID_ADDR_W-1:0] id_raddr;

  assign stat.clr_last = (clr_addr_r == KEY_W'(KEY_COUNT - 1));

  // limit in force is the smaller of the register and the ring size
  assign limit_eff = (queue_limit_r > LIMIT_W'(QUEUE_DEPTH)) ?
                     LIMIT_W'(QUEUE_DEPTH) : queue_limit_r;

  // lock and queue decision
  always_comb begin
    status_nxt = ST_OK;
    meta_nxt   = meta_q_r;
    enq_we     = 1'b0;
    at_head    = (meta_q_r.fill != '0) && (id_q_r == id_r);
    unique case (req_r)
      REQ_ENQ: begin
        if (meta_q_r.fill >= limit_eff) begin
          status_nxt = ST_FULL;
        end else begin
          enq_we        = 1'b1;
          meta_nxt.tail = meta_q_r.tail + QPTR_W'(1);
          meta_nxt.fill = meta_q_r.fill + FILL_W'(1);
        end
      end
      REQ_SHARED: begin
        if (!at_head) begin
          status_nxt = ST_NOT_HEAD;
        end else if (meta_q_r.writer || meta_q_r.rcnt >= RCNT_MAX) begin
          status_nxt = ST_CONFLICT;
        end else begin
          meta_nxt.rcnt = meta_q_r.rcnt + RCNT_W'(1);
          meta_nxt.head = meta_q_r.head + QPTR_W'(1);
          meta_nxt.fill = meta_q_r.fill - FILL_W'(1);
        end
      end
      REQ_EXCL: begin
        if (!at_head) begin
          status_nxt = ST_NOT_HEAD;
        end else if (meta_q_r.writer || meta_q_r.rcnt != '0) begin
          status_nxt = ST_CONFLICT;
        end else begin
          meta_nxt.writer = 1'b1;
          meta_nxt.head   = meta_q_r.head + QPTR_W'(1);
          meta_nxt.fill   = meta_q_r.fill - FILL_W'(1);
        end
      end
      REQ_UPGRADE: begin
        if (!at_head) begin
          status_nxt = ST_NOT_HEAD;
        end else if (meta_q_r.writer || meta_q_r.rcnt != RCNT_W'(1)) begin
          status_nxt = ST_CONFLICT;
        end else begin
          meta_nxt.rcnt   = '0;
          meta_nxt.writer = 1'b1;
          meta_nxt.head   = meta_q_r.head + QPTR_W'(1);
          meta_nxt.fill   = meta_q_r.fill - FILL_W'(1);
        end
      end
      REQ_REL_SH: begin
        if (meta_q_r.writer || meta_q_r.rcnt == '0) begin
          status_nxt = ST_REL_ERR;
        end else begin
          meta_nxt.rcnt = meta_q_r.rcnt - RCNT_W'(1);
        end
      end
      REQ_REL_EX: begin
        if (!meta_q_r.writer) begin
          status_nxt = ST_REL_ERR;
        end else begin
          meta_nxt.writer = 1'b0;
        end
      end
      default: status_nxt = ST_REL_ERR;
    endcase
  end

  // record write port: clearing pass after reset, then updates
  assign meta_we    = cmd.clr_wr || cmd.exec;
  assign meta_waddr = cmd.clr_wr ? clr_addr_r : key_r;
  assign meta_wdata = cmd.clr_wr ? meta_t'('0) : meta_nxt;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.meta_rd) begin
      meta_q_r <= meta_mem[key_r];
    end
  end

  // id ring: write at the tail, read the old or the new head
  assign id_raddr = cmd.head_rd ? {key_r, meta_q_r.head} : {key_r, nhead_r};

  always_ff @(posedge clk) begin
    if (cmd.exec && enq_we) begin
      id_mem[{key_r, meta_q_r.tail}] <= id_r;
    end
    if (cmd.head_rd || cmd.nhead_rd) begin
      id_q_r <= id_mem[id_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r    <= '0;
      queue_limit_r <= LIMIT_RESET;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + KEY_W'(1);
      end
      if (cfg_valid) begin
        queue_limit_r <= cfg_data;
      end
    end
  end

  // request, decision and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_tdata[REQ_W-1:0];
      key_r <= in_tdata[REQ_W +: KEY_W];
      id_r  <= in_tdata[REQ_W+KEY_W +: TXID_W];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      nhead_r  <= meta_nxt.head;
      nfill_r  <= meta_nxt.fill;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_head_r   <= (nfill_r == '0) ? '0 : id_q_r;
      out_fill_r   <= nfill_r;
    end
  end

  assign out_tdata = {(OUT_DATA_W - STATUS_W - TXID_W - FILL_W)'(0),
                      out_fill_r, out_head_r, out_status_r};

endmodule
`default_nettype wire
